// ----- src/jbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG entropy encoder package
// Shared widths, commands, register addresses and Huffman code lookups.
// ----------------------------------------------------------------------------
package jbe_pkg;

  localparam int unsigned CodeW  = 27;
  localparam int unsigned CountW = 5;
  localparam int unsigned CoefW  = 12;

  typedef enum logic {
    CMD_CODE  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  localparam logic [1:0] REG_TABLE_SELECT = 2'd0;
  localparam logic [7:0] SYM_ZRL = 8'hF0;
  localparam logic [7:0] SYM_EOB = 8'h00;

  typedef struct packed {
    logic [CodeW-1:0]  code_bits;
    logic [CountW-1:0] bit_count;
    logic              last_of_run;
  } chunk_t;

  typedef struct packed {
    logic [15:0] code;
    logic [4:0]  len;
  } hcode_t;

  function automatic hcode_t dc_lookup(input logic tsel, input logic [3:0] cat);
    hcode_t h;
    h = '{code: 16'd0, len: 5'd0};
    if (!tsel) begin
      case (cat)
        4'd0: h = '{16'h0000, 5'd2};
        4'd1: h = '{16'h0002, 5'd3};
        4'd2: h = '{16'h0003, 5'd3};
        4'd3: h = '{16'h0004, 5'd3};
        4'd4: h = '{16'h0005, 5'd3};
        4'd5: h = '{16'h0006, 5'd3};
        4'd6: h = '{16'h000E, 5'd4};
        4'd7: h = '{16'h001E, 5'd5};
        4'd8: h = '{16'h003E, 5'd6};
        4'd9: h = '{16'h007E, 5'd7};
        4'd10: h = '{16'h00FE, 5'd8};
        4'd11: h = '{16'h01FE, 5'd9};
        default: h = '{16'h0000, 5'd0};
      endcase
    end else begin
      case (cat)
        4'd0: h = '{16'h0000, 5'd2};
        4'd1: h = '{16'h0001, 5'd2};
        4'd2: h = '{16'h0002, 5'd2};
        4'd3: h = '{16'h0006, 5'd3};
        4'd4: h = '{16'h000E, 5'd4};
        4'd5: h = '{16'h001E, 5'd5};
        4'd6: h = '{16'h003E, 5'd6};
        4'd7: h = '{16'h007E, 5'd7};
        4'd8: h = '{16'h00FE, 5'd8};
        4'd9: h = '{16'h01FE, 5'd9};
        4'd10: h = '{16'h03FE, 5'd10};
        4'd11: h = '{16'h07FE, 5'd11};
        default: h = '{16'h0000, 5'd0};
      endcase
    end
    return h;
  endfunction

  // Canonical code construction over the Annex K AC count and symbol lists.
  function automatic hcode_t ac_lookup(input logic tsel, input logic [7:0] sym);
    logic [7:0] syms [0:161];
    logic [7:0] cnt [0:15];
    logic [7:0] lst0 [0:161];
    logic [7:0] lst1 [0:161];
    int unsigned code;
    int unsigned idx;
    hcode_t h;
    lst0 = '{8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
      8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,8'h23,
      8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,
      8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h34,
      8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
      8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,8'h66,
      8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,
      8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,
      8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,
      8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,
      8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,
      8'he1,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,
      8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    lst1 = '{8'h00,8'h01,8'h02,8'h03,8'h11,8'h04,8'h05,8'h21,8'h31,8'h06,8'h12,8'h41,
      8'h51,8'h07,8'h61,8'h71,8'h13,8'h22,8'h32,8'h81,8'h08,8'h14,8'h42,8'h91,8'ha1,
      8'hb1,8'hc1,8'h09,8'h23,8'h33,8'h52,8'hf0,8'h15,8'h62,8'h72,8'hd1,8'h0a,8'h16,
      8'h24,8'h34,8'he1,8'h25,8'hf1,8'h17,8'h18,8'h19,8'h1a,8'h26,8'h27,8'h28,8'h29,
      8'h2a,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,
      8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h63,8'h64,8'h65,
      8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,
      8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h92,8'h93,8'h94,8'h95,
      8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,
      8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,
      8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,
      8'hd9,8'hda,8'he2,8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf2,8'hf3,
      8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa};
    if (!tsel) begin
      cnt = '{8'd0,8'd2,8'd1,8'd3,8'd3,8'd2,8'd4,8'd3,8'd5,8'd5,8'd4,8'd4,8'd0,8'd0,
        8'd1,8'd125};
      syms = lst0;
    end else begin
      cnt = '{8'd0,8'd2,8'd1,8'd2,8'd4,8'd4,8'd3,8'd4,8'd7,8'd5,8'd4,8'd4,8'd0,8'd1,
        8'd2,8'd119};
      syms = lst1;
    end
    h = '{code: 16'd0, len: 5'd0};
    code = 0;
    idx = 0;
    for (int l = 1; l <= 16; l++) begin
      for (int k = 0; k < 162; k++) begin
        if (k < int'(cnt[l-1]) && idx < 162) begin
          if (syms[idx] == sym) begin
            h.code = code[15:0];
            h.len  = 5'(l);
          end
          code++;
          idx++;
        end
      end
      code = code << 1;
    end
    return h;
  endfunction

endpackage

// ----- src/jbe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG entropy encoder stream interface
// Valid/ready channel that carries one payload of a given type.
// ----------------------------------------------------------------------------
interface jbe_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/jbe_coder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG entropy encoder symbol coder
// Turns one registered item into up to four chunks and updates block state.
// ----------------------------------------------------------------------------
module jbe_coder (
  input  logic                        tsel,
  input  logic                        cmd,
  input  logic signed [11:0]          coef,
  input  logic signed [11:0]          prev_dc,
  input  logic [5:0]                  pos,
  input  logic [5:0]                  run,
  input  logic [2:0]                  phase,
  output logic signed [11:0]          prev_dc_nxt,
  output logic [5:0]                  pos_nxt,
  output logic [5:0]                  run_nxt,
  output logic [2:0]                  phase_nxt,
  output logic [2:0]                  n_out,
  output jbe_pkg::chunk_t             chunks [4]
);

  logic signed [12:0] c13, dcc, diff, dsat, acc, val;
  logic [11:0] mag, mbits;
  logic [3:0] cat;
  logic [1:0] nzrl;
  logic [3:0] rlow;
  jbe_pkg::hcode_t hd, ha, hz, he;
  logic [4:0] tot, fin_len;
  logic [26:0] fin_bits;
  logic [3:0] pad;
  logic [4:0] lens [4];

  always_comb begin
    c13  = 13'(coef);
    dcc  = (c13 < -13'sd2047) ? -13'sd2047 : c13;
    diff = dcc - 13'(prev_dc);
    dsat = (diff > 13'sd2047) ? 13'sd2047 : ((diff < -13'sd2047) ? -13'sd2047 : diff);
    acc  = (c13 > 13'sd1023) ? 13'sd1023 : ((c13 < -13'sd1023) ? -13'sd1023 : c13);
    val  = (pos == 6'd0) ? dsat : acc;
    mag  = val[12] ? 12'(-val) : val[11:0];
    cat  = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) cat = 4'(i + 1);
    end
    mbits = (val[12] ? 12'(val - 13'sd1) : val[11:0]) & 12'((13'd1 << cat) - 13'd1);
    nzrl = (run > 6'd47) ? 2'd3 : ((run > 6'd31) ? 2'd2 : ((run > 6'd15) ? 2'd1 : 2'd0));
    rlow = run[3:0];
    hd = jbe_pkg::dc_lookup(tsel, cat);
    ha = jbe_pkg::ac_lookup(tsel, {rlow, cat});
    hz = jbe_pkg::ac_lookup(tsel, jbe_pkg::SYM_ZRL);
    he = jbe_pkg::ac_lookup(tsel, jbe_pkg::SYM_EOB);
    pad = 4'd8 - 4'(phase);

    prev_dc_nxt = prev_dc;
    pos_nxt = pos;
    run_nxt = run;
    n_out = 3'd0;
    fin_bits = '0;
    fin_len = '0;
    for (int i = 0; i < 4; i++) begin
      chunks[i] = '{code_bits: 27'(hz.code), bit_count: hz.len, last_of_run: 1'b0};
      lens[i] = 5'd0;
    end
    if (cmd == jbe_pkg::CMD_FLUSH) begin
      if (phase != 3'd0) begin
        n_out = 3'd1;
        fin_bits = 27'((9'd1 << pad) - 9'd1);
        fin_len = 5'(pad);
      end
    end else begin
      pos_nxt = pos + 6'd1;
      if (pos == 6'd0) begin
        prev_dc_nxt = dcc[11:0];
        run_nxt = 6'd0;
        n_out = 3'd1;
        fin_bits = 27'({hd.code, 12'd0} >> (5'd12 - 5'(cat))) | 27'(mbits);
        fin_len = hd.len + 5'(cat);
      end else if (coef == 12'sd0) begin
        run_nxt = run + 6'd1;
        if (pos == 6'd63) begin
          n_out = 3'd1;
          fin_bits = 27'(he.code);
          fin_len = he.len;
        end
      end else begin
        run_nxt = 6'd0;
        n_out = 3'(nzrl) + 3'd1;
        fin_bits = 27'({ha.code, 11'd0} >> (5'd11 - 5'(cat))) | 27'(mbits);
        fin_len = ha.len + 5'(cat);
      end
      if (pos == 6'd63) run_nxt = 6'd0;
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) + 3'd1 < n_out) lens[i] = hz.len;
      if (3'(i) == n_out - 3'd1) begin
        chunks[i] = '{code_bits: fin_bits, bit_count: fin_len, last_of_run: 1'b1};
        lens[i] = fin_len;
      end
    end
    tot = 5'(phase) + lens[0] + lens[1] + lens[2] + lens[3];
    phase_nxt = tot[2:0];
  end

endmodule

// ----- src/jbe_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG entropy encoder output queue
// Chunk FIFO that takes up to four chunks a cycle and sends one a cycle while the sink is ready.
// ----------------------------------------------------------------------------
module jbe_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      wr_n,
  input  jbe_pkg::chunk_t wr_data [4],
  output logic            has_room,
  jbe_if.source           out_ch
);

  jbe_pkg::chunk_t mem_r [8];
  logic [2:0] rd_ptr_r, wr_ptr_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic pop;

  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != 4'd0;
  assign out_ch.data = mem_r[rd_ptr_r];
  assign cnt_nxt = cnt_r + 4'(wr_n) - 4'(pop);
  assign has_room = (cnt_r + 4'(wr_n)) <= 4'd4;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < wr_n) mem_r[wr_ptr_r + 3'(i)] <= wr_data[i];
    end
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_r + 3'(pop);
      wr_ptr_r <= wr_ptr_r + wr_n;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- src/jpeg_block_entropy_encoder_core.sv -----
`timescale 1ns / 1ps
// Flow: an item is registered on acceptance, coded the next cycle into the
// output queue, and its chunks are then offered from that queue in order.
// Throughput: one item per cycle while the eight-entry chunk queue has room
// for four chunks; chunks, ZRL chunks included, drain at one per cycle from that queue while the sink is ready.
// Reset: synchronous active-low rst_n clears the block state, queue and table_select.
// ----------------------------------------------------------------------------
// JPEG baseline entropy encoder core
// Huffman codes quantized 8x8 block coefficients into bit chunks.
// ----------------------------------------------------------------------------
module jpeg_block_entropy_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  jbe_if.sink         in_ch,
  jbe_if.source       out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic tsel_r, v_r, cmd_r, room;
  logic signed [11:0] coef_r, pdc_r, pdc_nxt;
  logic [5:0] pos_r, run_r, pos_nxt, run_nxt;
  logic [2:0] ph_r, ph_nxt, n_out;
  jbe_pkg::chunk_t chunks [4];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, tsel_r};
  assign in_ch.ready = room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsel_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == jbe_pkg::REG_TABLE_SELECT) begin
      tsel_r <= cfg_pwdata[0];
    end
  end

  jbe_coder u_coder (
    .tsel(tsel_r), .cmd(cmd_r), .coef(coef_r), .prev_dc(pdc_r), .pos(pos_r),
    .run(run_r), .phase(ph_r), .prev_dc_nxt(pdc_nxt), .pos_nxt(pos_nxt),
    .run_nxt(run_nxt), .phase_nxt(ph_nxt), .n_out(n_out), .chunks(chunks)
  );

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.data[12];
      coef_r <= in_ch.data[11:0];
    end
    if (!rst_n) begin
      v_r <= 1'b0;
      pdc_r <= '0;
      pos_r <= '0;
      run_r <= '0;
      ph_r <= '0;
    end else begin
      v_r <= in_ch.valid && in_ch.ready;
      if (v_r) begin
        pdc_r <= pdc_nxt;
        pos_r <= pos_nxt;
        run_r <= run_nxt;
        ph_r <= ph_nxt;
      end
    end
  end

  jbe_out_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_n(v_r ? n_out : 3'd0), .wr_data(chunks),
    .has_room(room), .out_ch(out_ch)
  );

endmodule
